@@ hw/rtl/escaped_double_byte_to_utf8_unit_macros.svh @@
// Assertion macros shared by the escaped double-byte to UTF-8 transcoder.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ESCAPED_DOUBLE_BYTE_TO_UTF8_UNIT_MACROS_SVH
`define ESCAPED_DOUBLE_BYTE_TO_UTF8_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define EDBU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edbu: same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define EDBU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edbu: next-cycle check failed");

`else

`define EDBU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EDBU_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/edbu_pkg.sv @@
// Types, constants and the UTF-8 encoder shared by the transcoder modules.
// No dependencies.
package edbu_pkg;

  localparam logic [7:0]  ESC_BYTE   = 8'hFF;
  localparam logic [15:0] CP_ONE_MAX = 16'h007F;
  localparam logic [15:0] CP_TWO_MAX = 16'h07FF;
  localparam logic [7:0]  LEAD_TWO   = 8'hC0;
  localparam logic [7:0]  LEAD_THREE = 8'hE0;
  localparam logic [7:0]  CONT_BYTE  = 8'h80;

  // One queued job: up to three data bytes, optionally followed by the terminator.
  typedef struct packed {
    logic [1:0]      n_data;
    logic [2:0][7:0] data;
    logic            has_term;
    logic            trunc;
  } job_t;

  function automatic job_t utf8_encode(input logic [15:0] cp);
    job_t j;
    j = '0;
    if (cp <= CP_ONE_MAX) begin
      j.n_data  = 2'd1;
      j.data[0] = cp[7:0];
    end else if (cp <= CP_TWO_MAX) begin
      j.n_data  = 2'd2;
      j.data[0] = LEAD_TWO | {3'b000, cp[10:6]};
      j.data[1] = CONT_BYTE | {2'b00, cp[5:0]};
    end else begin
      j.n_data  = 2'd3;
      j.data[0] = LEAD_THREE | {4'b0000, cp[15:12]};
      j.data[1] = CONT_BYTE | {2'b00, cp[11:6]};
      j.data[2] = CONT_BYTE | {2'b00, cp[5:0]};
    end
    return j;
  endfunction

endpackage

@@ hw/rtl/edbu_fifo.sv @@
// Short job queue between the front and back parts of the transcoder.
// Depends on edbu_pkg for the job type.
module edbu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  edbu_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output edbu_pkg::job_t pop_job,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  edbu_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ hw/rtl/edbu_front.sv @@
// Front part: takes input requests, tracks the escape phase and queues jobs.
// Depends on edbu_pkg and the assertion macro header.
`include "escaped_double_byte_to_utf8_unit_macros.svh"

module edbu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           push,
  output edbu_pkg::job_t push_job,
  input  logic           full
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  phase_t         phase_r, phase_nxt;
  logic [7:0]     high_r, high_nxt;
  logic           accept;
  edbu_pkg::job_t job;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    high_nxt  = high_r;
    job       = '0;
    case (phase_r)
      PH_HIGH: begin
        high_nxt  = in_byte;
        phase_nxt = PH_LOW;
      end
      PH_LOW: begin
        job       = edbu_pkg::utf8_encode({high_r, in_byte});
        phase_nxt = PH_IDLE;
        high_nxt  = '0;
      end
      default: begin
        if (in_byte == edbu_pkg::ESC_BYTE) begin
          phase_nxt = PH_HIGH;
          high_nxt  = '0;
        end else begin
          job.n_data  = 2'd1;
          job.data[0] = in_byte;
          phase_nxt   = PH_IDLE;
        end
      end
    endcase
    if (in_last) begin
      job.has_term = 1'b1;
      job.trunc    = (phase_nxt != PH_IDLE);
      phase_nxt    = PH_IDLE;
      high_nxt     = '0;
    end
  end

  assign push     = accept && ((job.n_data != 2'd0) || job.has_term);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      high_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
    end
  end

  `EDBU_ASSERT_NXT(a_high_to_low, clk, rst_n, accept && (phase_r == PH_HIGH) && !in_last, phase_r == PH_LOW)
  `EDBU_ASSERT_NXT(a_last_to_idle, clk, rst_n, accept && in_last, phase_r == PH_IDLE)
  `EDBU_ASSERT_IMP(a_last_queued, clk, rst_n, accept && in_last, push && push_job.has_term)

endmodule

@@ hw/rtl/edbu_back.sv @@
// Back part: takes jobs from the queue and sends their bytes one per cycle when not stalled.
// Depends on edbu_pkg and the assertion macro header.
`include "escaped_double_byte_to_utf8_unit_macros.svh"

module edbu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           empty,
  output logic           pop,
  input  edbu_pkg::job_t pop_job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_truncated
);

  edbu_pkg::job_t job_r, job_nxt;
  logic           job_valid_r, job_valid_nxt;
  logic [1:0]     idx_r, idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_byte_r, out_byte_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_trunc_r, out_trunc_nxt;
  logic [2:0]     total;
  logic           last_item;
  logic           out_free;
  logic [7:0]     data_sel;

  assign total     = {1'b0, job_r.n_data} + {2'b00, job_r.has_term};
  assign last_item = (({1'b0, idx_r} + 3'd1) == total);
  assign out_free  = !out_valid_r || out_ready;
  assign pop       = !empty && (!job_valid_r || (out_free && last_item));

  always_comb begin
    case (idx_r)
      2'd0:    data_sel = job_r.data[0];
      2'd1:    data_sel = job_r.data[1];
      2'd2:    data_sel = job_r.data[2];
      default: data_sel = '0;
    endcase
  end

  always_comb begin
    job_nxt       = job_r;
    job_valid_nxt = job_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_trunc_nxt = out_trunc_r;
    if (out_free) begin
      out_valid_nxt = job_valid_r;
      if (job_valid_r) begin
        if (idx_r < job_r.n_data) begin
          out_byte_nxt  = data_sel;
          out_last_nxt  = 1'b0;
          out_trunc_nxt = 1'b0;
        end else begin
          out_byte_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_trunc_nxt = job_r.trunc;
        end
        if (last_item) begin
          job_valid_nxt = 1'b0;
          idx_nxt       = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
    if (pop) begin
      job_nxt       = pop_job;
      job_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

  `EDBU_ASSERT_NXT(a_job_sent, clk, rst_n, job_valid_r && out_free, out_valid_r)
  `EDBU_ASSERT_IMP(a_idx_in_job, clk, rst_n, job_valid_r, ({1'b0, idx_r} < total))
  `EDBU_ASSERT_IMP(a_term_zero, clk, rst_n, out_valid_r && out_last_r, out_byte_r == 8'h00)
  `EDBU_ASSERT_IMP(a_trunc_on_term, clk, rst_n, out_valid_r && out_trunc_r, out_last_r)

endmodule

@@ hw/rtl/escaped_double_byte_to_utf8_unit.sv @@
// Escaped double-byte to UTF-8 transcoder: one input byte per cycle, one output
// byte per cycle when not stalled. An input request is taken every cycle while
// the job queue has room; it passes through the queue and the job register
// before it reaches the output register. The output side sends one byte per
// cycle unless out_ready stalls it, so an escape (three input bytes, up to three
// output bytes) keeps pace, while a string end adds a zero terminator byte.
// QUEUE_DEPTH sets how many jobs can wait between the front and back parts.
module escaped_double_byte_to_utf8_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_truncated
);

  logic           push, full, pop, empty;
  edbu_pkg::job_t push_job, pop_job;

  edbu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  edbu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  edbu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .pop_job       (pop_job),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_truncated (out_truncated)
  );

endmodule
